// ----- src/assert_macros.svh -----
// assertion macros shared by the nec ir transmitter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/nirt_pkg.sv -----
// types and constants for the nec ir frame transmitter
// no dependencies; used by every module of the block but nirt_fifo
`timescale 1ns / 1ps
`default_nettype none

package nirt_pkg;

   // field widths
   localparam int CODE_W     = 32;
   localparam int UNIT_W     = 12;
   localparam int HALF_W     = 8;
   localparam int TIME_W     = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_UNIT_TIME    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CARRIER_HALF = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LEADER_MARK  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LEADER_SPACE = 2'd3;

   // register reset values
   localparam logic [UNIT_W-1:0] UNIT_TIME_RESET    = 12'd562;
   localparam logic [HALF_W-1:0] CARRIER_HALF_RESET = 8'd13;
   localparam logic [TIME_W-1:0] LEADER_MARK_RESET  = 16'd9000;
   localparam logic [TIME_W-1:0] LEADER_SPACE_RESET = 16'd4500;

   typedef struct packed {
      logic              req_type;
      logic [CODE_W-1:0] code;
   } req_item_type;

   typedef struct packed {
      logic led_on;
      logic busy_res;
      logic dropped;
   } rsp_item_type;

   typedef enum logic {
      OP_TICK,
      OP_SEND
   } op_type;

   // classified item held between front and engine
   typedef struct packed {
      op_type            op;
      logic [CODE_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LMARK,
      PH_LSPACE,
      PH_BMARK,
      PH_BSPACE,
      PH_STOP
   } phase_type;

endpackage

`default_nettype wire

// ----- src/nirt_fifo.sv -----
// small register queue with registered count, used on both sides of the engine
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nirt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   // status from the count register
   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push_ok) - CntW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CntW'(DEPTH), "queue count beyond depth")
   `ASSERT_IMPLIES(a_full_not_empty, clock, reset, full, !empty, "queue full and empty at once")
   `ASSERT_IMPLIES(a_empty_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "empty queue with split pointers")

endmodule

`default_nettype wire

// ----- src/nirt_front.sv -----
// front end: takes request items, classifies them and queues them for the engine
// depends on nirt_pkg and nirt_fifo
`timescale 1ns / 1ps
`default_nettype none

module nirt_front #(
   parameter int DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire nirt_pkg::req_item_type req_data,
   output logic                       cmd_valid,
   input  wire logic                  cmd_pop,
   output nirt_pkg::cmd_type          cmd
);

   localparam int CmdW = $bits(nirt_pkg::cmd_type);

   nirt_pkg::cmd_type cmd_new;
   logic [CmdW-1:0]   cmd_bits;
   logic              cmd_empty;

   // classify the item: tick or send
   always_comb begin
      cmd_new.op   = req_data.req_type ? nirt_pkg::OP_SEND : nirt_pkg::OP_TICK;
      cmd_new.code = req_data.code;
   end

   nirt_fifo #(
      .WIDTH(CmdW),
      .DEPTH(DEPTH)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push (req_push),
      .wdata(cmd_new),
      .full (req_full),
      .pop  (cmd_pop),
      .rdata(cmd_bits),
      .empty(cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
   assign cmd       = nirt_pkg::cmd_type'(cmd_bits);

endmodule

`default_nettype wire

// ----- src/nirt_engine.sv -----
// back end: config registers and the frame sequencer, one item per cycle while the result queue has room
// depends on nirt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nirt_engine #(
   parameter int CODE_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nirt_pkg::csr_write_type csr,
   input  wire logic                   cmd_valid,
   input  wire nirt_pkg::cmd_type      cmd,
   output logic                        cmd_pop,
   input  wire logic                   res_full,
   output logic                        res_push,
   output nirt_pkg::rsp_item_type      res_item
);

   localparam int BitsW  = $clog2(CODE_BITS + 1);
   localparam int UnitW  = nirt_pkg::UNIT_W;
   localparam int HalfW  = nirt_pkg::HALF_W;
   localparam int TimeW  = nirt_pkg::TIME_W;
   localparam int PerW   = HalfW + 1;

   // configuration
   logic [UnitW-1:0] unit_time_ff, unit_time_in;
   logic [HalfW-1:0] carrier_half_ff, carrier_half_in;
   logic [TimeW-1:0] lead_mark_ff, lead_mark_in;
   logic [TimeW-1:0] lead_space_ff, lead_space_in;

   // frame state
   nirt_pkg::phase_type  phase_ff, phase_in;
   logic [CODE_BITS-1:0] shift_ff, shift_in;
   logic [BitsW-1:0]     bits_left_ff, bits_left_in;
   logic [TimeW-1:0]     time_left_ff, time_left_in;
   logic [HalfW-1:0]     half_count_ff, half_count_in;
   logic                 level_ff, level_in;
   // carrier period taken at mark start and ticks left in the current period
   logic [PerW-1:0]      mark_period_ff, mark_period_in;
   logic [PerW-1:0]      per_left_ff, per_left_in;

   // derived values
   logic [HalfW-1:0] eff_half;
   logic [HalfW:0]   period;
   logic [UnitW+1:0] unit3;
   logic             lm_ok, ls_ok, bm_ok, bs_ok;
   logic             fire, is_send, in_mark;

   assign eff_half = (carrier_half_ff == '0) ? HalfW'(1) : carrier_half_ff;
   assign period   = {eff_half, 1'b0};
   assign unit3    = {1'b0, unit_time_ff, 1'b0} + {2'b00, unit_time_ff};
   // a mark is non-empty when it holds at least one whole carrier period
   assign lm_ok    = lead_mark_ff >= TimeW'(period);
   assign bm_ok    = TimeW'(unit_time_ff) >= TimeW'(period);
   assign ls_ok    = (lead_space_ff != '0);
   assign bs_ok    = (unit_time_ff != '0);
   assign fire     = cmd_valid && !res_full;
   assign is_send  = (cmd.op == nirt_pkg::OP_SEND);
   assign in_mark  = (phase_ff == nirt_pkg::PH_LMARK) || (phase_ff == nirt_pkg::PH_BMARK)
                     || (phase_ff == nirt_pkg::PH_STOP);

   // register writes
   always_comb begin
      unit_time_in    = unit_time_ff;
      carrier_half_in = carrier_half_ff;
      lead_mark_in    = lead_mark_ff;
      lead_space_in   = lead_space_ff;
      if (csr.we) begin
         unique case (csr.addr)
            nirt_pkg::REG_UNIT_TIME:    unit_time_in    = csr.data[UnitW-1:0];
            nirt_pkg::REG_CARRIER_HALF: carrier_half_in = csr.data[HalfW-1:0];
            nirt_pkg::REG_LEADER_MARK:  lead_mark_in    = csr.data[TimeW-1:0];
            nirt_pkg::REG_LEADER_SPACE: lead_space_in   = csr.data[TimeW-1:0];
            default: ;
         endcase
      end
   end

   // next state: advance the current segment, then skip empty ones
   always_comb begin
      nirt_pkg::phase_type  p;
      logic                 adv;
      logic                 seg_end;
      logic [TimeW-1:0]     rem;
      logic [CODE_BITS-1:0] sh;
      logic [BitsW-1:0]     bl;

      p       = phase_ff;
      adv     = 1'b0;
      seg_end = 1'b0;
      rem     = time_left_ff - TimeW'(1);
      sh      = shift_ff;
      bl      = bits_left_ff;

      phase_in       = phase_ff;
      shift_in       = shift_ff;
      bits_left_in   = bits_left_ff;
      time_left_in   = time_left_ff;
      half_count_in  = half_count_ff;
      level_in       = level_ff;
      mark_period_in = mark_period_ff;
      per_left_in    = per_left_ff;

      if (fire) begin
         if (is_send) begin
            // a send only starts a frame from idle
            if (phase_ff == nirt_pkg::PH_IDLE) begin
               sh  = CODE_BITS'(cmd.code);
               bl  = BitsW'(CODE_BITS);
               p   = nirt_pkg::PH_LMARK;
               adv = 1'b1;
            end
         end else if (phase_ff != nirt_pkg::PH_IDLE) begin
            time_left_in = rem;
            if (in_mark) begin
               // carrier half-period countdown
               if (half_count_ff <= HalfW'(1)) begin
                  level_in      = !level_ff;
                  half_count_in = eff_half;
               end else begin
                  half_count_in = half_count_ff - HalfW'(1);
               end
               // mark ends at a period boundary once no whole period is left
               if (per_left_ff <= PerW'(1)) begin
                  per_left_in = mark_period_ff;
                  seg_end     = (rem < TimeW'(mark_period_ff));
               end else begin
                  per_left_in = per_left_ff - PerW'(1);
               end
            end else begin
               seg_end = (rem == '0);
            end
            if (seg_end) begin
               adv = 1'b1;
               unique case (phase_ff)
                  nirt_pkg::PH_LMARK:  p = nirt_pkg::PH_LSPACE;
                  nirt_pkg::PH_LSPACE: p = nirt_pkg::PH_BMARK;
                  nirt_pkg::PH_BMARK:  p = nirt_pkg::PH_BSPACE;
                  nirt_pkg::PH_BSPACE: begin
                     sh = sh << 1;
                     if (bl != '0) begin
                        bl = bl - BitsW'(1);
                     end
                     p = (bl != '0) ? nirt_pkg::PH_BMARK : nirt_pkg::PH_STOP;
                  end
                  default: p = nirt_pkg::PH_IDLE;
               endcase
            end
         end
      end

      if (adv) begin
         // skip empty segments; lengths come from the registers as each segment starts
         if (p == nirt_pkg::PH_LMARK && !lm_ok) begin
            p = nirt_pkg::PH_LSPACE;
         end
         if (p == nirt_pkg::PH_LSPACE && !ls_ok) begin
            p = nirt_pkg::PH_BMARK;
         end
         if (p == nirt_pkg::PH_BMARK && !bm_ok) begin
            p = nirt_pkg::PH_BSPACE;
         end
         if (p == nirt_pkg::PH_BSPACE && !bs_ok) begin
            // empty bit space: consume the bit, all bits go if marks are empty too
            sh = sh << 1;
            if (bl != '0) begin
               bl = bl - BitsW'(1);
            end
            p = (bl != '0) ? nirt_pkg::PH_BMARK : nirt_pkg::PH_STOP;
            if (p == nirt_pkg::PH_BMARK && !bm_ok) begin
               p = nirt_pkg::PH_STOP;
            end
         end
         if (p == nirt_pkg::PH_STOP && !bm_ok) begin
            p = nirt_pkg::PH_IDLE;
         end

         phase_in     = p;
         shift_in     = sh;
         bits_left_in = bl;

         // load the new segment
         unique case (p)
            nirt_pkg::PH_LMARK: begin
               time_left_in   = lead_mark_ff;
               level_in       = 1'b1;
               half_count_in  = eff_half;
               mark_period_in = period;
               per_left_in    = period;
            end
            nirt_pkg::PH_LSPACE: begin
               time_left_in = lead_space_ff;
               level_in     = 1'b0;
            end
            nirt_pkg::PH_BMARK, nirt_pkg::PH_STOP: begin
               time_left_in   = TimeW'(unit_time_ff);
               level_in       = 1'b1;
               half_count_in  = eff_half;
               mark_period_in = period;
               per_left_in    = period;
            end
            nirt_pkg::PH_BSPACE: begin
               time_left_in = sh[CODE_BITS-1] ? TimeW'(unit3) : TimeW'(unit_time_ff);
               level_in     = 1'b0;
            end
            default: begin
               time_left_in  = '0;
               level_in      = 1'b0;
               half_count_in = '0;
            end
         endcase
      end
   end

   // result of the item in hand
   always_comb begin
      cmd_pop           = fire;
      res_push          = fire;
      res_item.led_on   = !is_send && in_mark && level_ff;
      res_item.busy_res = is_send ? (phase_in != nirt_pkg::PH_IDLE)
                                  : (phase_ff != nirt_pkg::PH_IDLE);
      res_item.dropped  = is_send && (phase_ff != nirt_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_time_ff    <= nirt_pkg::UNIT_TIME_RESET;
         carrier_half_ff <= nirt_pkg::CARRIER_HALF_RESET;
         lead_mark_ff    <= nirt_pkg::LEADER_MARK_RESET;
         lead_space_ff   <= nirt_pkg::LEADER_SPACE_RESET;
         phase_ff        <= nirt_pkg::PH_IDLE;
         shift_ff        <= '0;
         bits_left_ff    <= '0;
         time_left_ff    <= '0;
         half_count_ff   <= '0;
         level_ff        <= 1'b0;
         mark_period_ff  <= '0;
         per_left_ff     <= '0;
      end else begin
         unit_time_ff    <= unit_time_in;
         carrier_half_ff <= carrier_half_in;
         lead_mark_ff    <= lead_mark_in;
         lead_space_ff   <= lead_space_in;
         phase_ff        <= phase_in;
         shift_ff        <= shift_in;
         bits_left_ff    <= bits_left_in;
         time_left_ff    <= time_left_in;
         half_count_ff   <= half_count_in;
         level_ff        <= level_in;
         mark_period_ff  <= mark_period_in;
         per_left_ff     <= per_left_in;
      end
   end

   `ASSERT_IMPLIES(a_mark_half_live, clock, reset, in_mark, half_count_ff != '0, "carrier count empty inside a mark")
   `ASSERT_IMPLIES(a_idle_quiet, clock, reset, phase_ff == nirt_pkg::PH_IDLE, time_left_ff == '0 && !level_ff, "idle with time or carrier left")
   `ASSERT_IMPLIES(a_active_time, clock, reset, phase_ff != nirt_pkg::PH_IDLE, time_left_ff != '0, "active segment with no time left")
   `ASSERT_IMPLIES(a_bits_live, clock, reset, phase_ff == nirt_pkg::PH_BMARK || phase_ff == nirt_pkg::PH_BSPACE, bits_left_ff != '0 && bits_left_ff <= BitsW'(CODE_BITS), "bit phase with bad bit count")

endmodule

`default_nettype wire

// ----- src/nec_ir_frame_transmitter_top.sv -----
// nec ir frame transmitter: one led level per tick item, frames started by send items
// Channels: req_push/req_full take items {req_type, code}; req_type 0 is one
// microsecond tick, 1 loads a code and starts a frame. rsp_empty/rsp_pop hand
// back one result {led_on, busy_res, dropped} per item, in order.
// csr_we/csr_addr/csr_wdata write unit_time (0), carrier_half (1),
// leader_mark_time (2), leader_space_time (3); write only with no item in flight.
// Path: an accepted item waits in the command queue; its result goes to the result
// queue, which offers it. Throughput: one item per cycle while the result queue
// has room, set by the frame sequencer, which handles one item per clock.
// Stalls: a command queue and a result queue (QUEUE_DEPTH each) decouple the
// two sides; when rsp_pop holds off the result queue fills, the sequencer
// stops, then the command queue fills and req_full rises.
// A send while a frame runs is dropped and flagged in its result.
// Reset: synchronous; queues empty, sequencer idle, registers to defaults.
// Depends on nirt_pkg, nirt_front, nirt_engine and nirt_fifo.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_transmitter_top #(
   parameter int CODE_BITS   = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire nirt_pkg::req_item_type              req_data,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output nirt_pkg::rsp_item_type                   rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [nirt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [nirt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RspW = $bits(nirt_pkg::rsp_item_type);

   nirt_pkg::csr_write_type csr;
   nirt_pkg::cmd_type       cmd;
   nirt_pkg::rsp_item_type  res_item;
   logic                    cmd_valid;
   logic                    cmd_pop;
   logic                    res_full;
   logic                    res_push;
   logic [RspW-1:0]         rsp_bits;

   // bundle the write port
   always_comb begin
      csr.we   = csr_we;
      csr.addr = csr_addr;
      csr.data = csr_wdata;
   end

   nirt_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .cmd      (cmd)
   );

   nirt_engine #(
      .CODE_BITS(CODE_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .res_full (res_full),
      .res_push (res_push),
      .res_item (res_item)
   );

   // result queue towards the consumer
   nirt_fifo #(
      .WIDTH(RspW),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (res_push),
      .wdata(res_item),
      .full (res_full),
      .pop  (rsp_pop),
      .rdata(rsp_bits),
      .empty(rsp_empty)
   );

   assign rsp_data = nirt_pkg::rsp_item_type'(rsp_bits);

endmodule

`default_nettype wire

// ----- verif/nirt_frame_checker.sv -----
// result checker for the nec ir frame transmitter: watches the item, result and register ports
// keeps its own frame sequencer to predict led_on, busy_res and dropped for every item
// depends on nirt_pkg
`timescale 1ns / 1ps

module nirt_frame_checker #(
   parameter int FRAME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  logic                                  req_full,
   input  nirt_pkg::req_item_type                req_data,
   input  logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   input  nirt_pkg::rsp_item_type                rsp_data,
   input  logic                                  csr_we,
   input  logic [nirt_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [nirt_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                    fail_count,
   output int                                    pending_results
);

   import nirt_pkg::*;

   // register copies
   logic [UNIT_W-1:0] cfg_unit;
   logic [HALF_W-1:0] cfg_half;
   logic [TIME_W-1:0] cfg_lmark;
   logic [TIME_W-1:0] cfg_lspace;

   // sequencer copy
   phase_type   ph;
   logic [63:0] code_shift;
   int unsigned bits_to_go;
   int unsigned seg_ticks;
   int unsigned half_ticks;
   logic        carrier;

   rsp_item_type predicted_levels[$];
   int           bad_results = 0;

   function automatic int unsigned carrier_half_ticks();
      return (cfg_half == 0) ? 1 : cfg_half;
   endfunction

   // marks only last whole carrier periods
   function automatic int unsigned whole_periods(input int unsigned t);
      int unsigned period;
      period = 2 * carrier_half_ticks();
      return (t / period) * period;
   endfunction

   function automatic bit is_mark(input phase_type p);
      return p == PH_LMARK || p == PH_BMARK || p == PH_STOP;
   endfunction

   // segment order; leaving a bit space consumes one code bit
   function automatic phase_type following(input phase_type p);
      case (p)
         PH_LMARK:  return PH_LSPACE;
         PH_LSPACE: return PH_BMARK;
         PH_BMARK:  return PH_BSPACE;
         PH_BSPACE: begin
            code_shift = code_shift << 1;
            if (bits_to_go > 0)
               bits_to_go--;
            if (bits_to_go > 0)
               return PH_BMARK;
            return PH_STOP;
         end
         default:   return PH_IDLE;
      endcase
   endfunction

   // load the current segment length, skipping empty ones
   function automatic void enter_segment();
      seg_ticks = 0;
      while (ph != PH_IDLE && seg_ticks == 0) begin
         case (ph)
            PH_LMARK:  seg_ticks = whole_periods(cfg_lmark);
            PH_LSPACE: seg_ticks = cfg_lspace;
            PH_BMARK:  seg_ticks = whole_periods(cfg_unit);
            PH_BSPACE: seg_ticks = code_shift[FRAME_BITS-1] ? 3 * cfg_unit : cfg_unit;
            PH_STOP:   seg_ticks = whole_periods(cfg_unit);
            default:   seg_ticks = 0;
         endcase
         if (seg_ticks == 0)
            ph = following(ph);
      end
      if (ph == PH_IDLE) begin
         seg_ticks = 0;
         carrier = 1'b0;
         half_ticks = 0;
      end else if (is_mark(ph)) begin
         carrier = 1'b1;
         half_ticks = carrier_half_ticks();
      end else begin
         carrier = 1'b0;
      end
   endfunction

   always @(posedge clock) begin : track
      rsp_item_type want;
      rsp_item_type pred;
      if (reset) begin
         cfg_unit = UNIT_TIME_RESET;
         cfg_half = CARRIER_HALF_RESET;
         cfg_lmark = LEADER_MARK_RESET;
         cfg_lspace = LEADER_SPACE_RESET;
         ph = PH_IDLE;
         code_shift = '0;
         bits_to_go = 0;
         seg_ticks = 0;
         half_ticks = 0;
         carrier = 1'b0;
         predicted_levels.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               REG_UNIT_TIME:    cfg_unit = csr_wdata[UNIT_W-1:0];
               REG_CARRIER_HALF: cfg_half = csr_wdata[HALF_W-1:0];
               REG_LEADER_MARK:  cfg_lmark = csr_wdata[TIME_W-1:0];
               REG_LEADER_SPACE: cfg_lspace = csr_wdata[TIME_W-1:0];
               default: ;
            endcase
         end

         // compare each accepted result with the oldest prediction
         if (rsp_pop && !rsp_empty) begin
            if (predicted_levels.size() == 0) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("unexpected result: led_on %0b busy_res %0b dropped %0b",
                           rsp_data.led_on, rsp_data.busy_res, rsp_data.dropped);
            end else begin
               want = predicted_levels.pop_front();
               if (rsp_data.led_on !== want.led_on || rsp_data.busy_res !== want.busy_res ||
                   rsp_data.dropped !== want.dropped) begin
                  bad_results++;
                  if (bad_results <= 10)
                     $display("result mismatch at %0t: expected led_on %0b busy_res %0b dropped %0b, got %0b %0b %0b",
                              $realtime, want.led_on, want.busy_res, want.dropped,
                              rsp_data.led_on, rsp_data.busy_res, rsp_data.dropped);
               end
            end
         end

         // predict the result of each accepted item
         if (req_push && !req_full) begin
            pred = '0;
            if (req_data.req_type == OP_SEND) begin
               if (ph != PH_IDLE) begin
                  pred.dropped = 1'b1;
               end else begin
                  code_shift = 64'(req_data.code) & ((64'd1 << FRAME_BITS) - 64'd1);
                  bits_to_go = FRAME_BITS;
                  ph = PH_LMARK;
                  enter_segment();
               end
               pred.busy_res = (ph != PH_IDLE);
            end else if (ph != PH_IDLE) begin
               pred.busy_res = 1'b1;
               if (is_mark(ph)) begin
                  pred.led_on = carrier;
                  if (half_ticks > 0)
                     half_ticks--;
                  if (half_ticks == 0) begin
                     carrier = ~carrier;
                     half_ticks = carrier_half_ticks();
                  end
               end
               if (seg_ticks > 0)
                  seg_ticks--;
               if (seg_ticks == 0) begin
                  ph = following(ph);
                  enter_segment();
               end
            end
            predicted_levels.push_back(pred);
         end
      end
      pending_results <= predicted_levels.size();
      fail_count <= bad_results;
   end

endmodule

// ----- verif/tb_top.sv -----
// top of the nec ir frame transmitter testbench: clock, reset, item and register stimulus
// and the verdict; checking is done by nirt_frame_checker
// depends on nirt_pkg, nirt_frame_checker and nec_ir_frame_transmitter_top
`timescale 1ns / 1ps

module tb_top;

   import nirt_pkg::*;

   localparam int LIMIT_CYCLES  = 12_000_000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 120;
   localparam int RANDOM_PHASES = 9;
   // a short stretch into the leader mark at the top settings
   localparam int LONG_TICKS    = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   req_item_type          req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = REG_UNIT_TIME;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit          idling_on = 1'b1;
   int          hold_asks = 0;
   int          hold_served = 0;
   int          pop_wait = 0;
   int unsigned cycle_count = 0;
   int          fail_count;
   int          pending_results;

   always #5 clock = ~clock;

   nec_ir_frame_transmitter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   nirt_frame_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data        (req_data),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("nec_ir_frame_transmitter_top test failed");
         $finish;
      end
   end

   // result side: random stall bursts, and one long hold-off on request
   always @(posedge clock) begin
      if (pop_wait > 0) begin
         rsp_pop <= 1'b0;
         pop_wait <= pop_wait - 1;
      end else if (hold_asks != hold_served) begin
         rsp_pop <= 1'b0;
         hold_served <= hold_asks;
         pop_wait <= HOLD_CYCLES - 1;
      end else if (idling_on && $urandom_range(0, 19) == 0) begin
         rsp_pop <= 1'b0;
         pop_wait <= $urandom_range(0, 17);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // offer one item, hold it until accepted, then maybe pause
   task automatic offer(input op_type kind, input logic [CODE_W-1:0] code);
      req_item_type it;
      it.req_type = kind;
      it.code = code;
      req_data <= it;
      req_push <= 1'b1;
      do
         @(posedge clock);
      while (req_full);
      if (idling_on && $urandom_range(0, 19) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every predicted result to come back
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   task automatic load_settings(input int unit, input int half, input int lmark,
                                input int lspace);
      csr_we <= 1'b1;
      csr_addr <= REG_UNIT_TIME;
      csr_wdata <= CSR_DATA_W'(unit);
      @(posedge clock);
      csr_addr <= REG_CARRIER_HALF;
      csr_wdata <= CSR_DATA_W'(half);
      @(posedge clock);
      csr_addr <= REG_LEADER_MARK;
      csr_wdata <= CSR_DATA_W'(lmark);
      @(posedge clock);
      csr_addr <= REG_LEADER_SPACE;
      csr_wdata <= CSR_DATA_W'(lspace);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly ticks with a frame start up front; stray sends land on idle or busy frames
   task automatic run_frames(input int count, input int send_odds);
      op_type kind;
      offer(OP_SEND, $urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, send_odds - 1) == 0)
            kind = OP_SEND;
         else
            kind = OP_TICK;
         offer(kind, $urandom);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, frame of all zeros, sends dropped while busy
      load_settings(2, 1, 6, 3);
      offer(OP_TICK, 32'hFFFF_FFFF);
      offer(OP_SEND, 32'h0000_0000);
      offer(OP_SEND, 32'hFFFF_FFFF);
      repeat (12) offer(OP_TICK, $urandom);
      offer(OP_SEND, 32'h8000_0001);
      repeat (4) offer(OP_TICK, 32'h0000_0000);
      run_frames(PHASE_ITEMS, 40);

      // random short settings, one phase with the result side held off
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         load_settings($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 16),
                       $urandom_range(0, 10));
         if (p == 2)
            hold_asks <= hold_asks + 1;
         run_frames(PHASE_ITEMS, 40);
      end

      // top settings for every register, then the bottom ones written mid frame
      drain();
      load_settings(4095, 255, 65535, 65535);
      offer(OP_SEND, $urandom | 32'h8000_0000);
      run_frames(LONG_TICKS, 1000);
      drain();
      load_settings(1, 1, 1, 0);
      run_frames(PHASE_ITEMS, 40);

      // closing stretch without idling
      drain();
      idling_on <= 1'b0;
      load_settings($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 16),
                    $urandom_range(0, 10));
      run_frames(PHASE_ITEMS, 40);

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("nec_ir_frame_transmitter_top test passed");
      else
         $display("nec_ir_frame_transmitter_top test failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/nirt_pkg.sv
src/nirt_fifo.sv
src/nirt_front.sv
src/nirt_engine.sv
src/nec_ir_frame_transmitter_top.sv
verif/nirt_frame_checker.sv
verif/tb_top.sv
